@@ sv/assert_macros.svh @@
// Assertion macros used by the decoder controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, sampled on clk, off during reset.
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, sampled on clk, off during reset.
`define ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMP(lbl, ante, cons, msg)
`define ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

@@ sv/datd_pkg.sv @@
// Shared types, codes and helper functions of the address table decoder.
`default_nettype none
package datd_pkg;

  localparam int unsigned DIV_STEPS = 64;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_FORMAT  = 4'd1,
    PH_VERSION = 4'd2,
    PH_NAMELEN = 4'd3,
    PH_NAME    = 4'd4,
    PH_PTRSIZE = 4'd5,
    PH_COUNT   = 4'd6,
    PH_TYPE    = 4'd7,
    PH_IDF     = 4'd8,
    PH_OFFF    = 4'd9
  } phase_t;

  typedef enum logic [1:0] {
    KIND_ENTRY = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_BAD_FORMAT = 3'd1,
    ERR_ZERO_PTR   = 3'd2,
    ERR_BAD_ID     = 3'd3,
    ERR_TRUNCATED  = 3'd4
  } err_t;

  // Field coding of the id and offset nibbles
  typedef enum logic [2:0] {
    CODE_ABS64   = 3'd0,
    CODE_PLUS1   = 3'd1,
    CODE_ADD_U8  = 3'd2,
    CODE_SUB_U8  = 3'd3,
    CODE_ADD_U16 = 3'd4,
    CODE_SUB_U16 = 3'd5,
    CODE_ABS_U16 = 3'd6,
    CODE_ABS_U32 = 3'd7
  } code_t;

  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_DIV_GO   = 3'd1,
    ST_DIV_WAIT = 3'd2,
    ST_APPLY    = 3'd3,
    ST_MUL_LO   = 3'd4,
    ST_MUL_HI   = 3'd5,
    ST_FIN      = 3'd6
  } ctrl_state_t;

  typedef struct packed {
    kind_t       kind;
    err_t        err;
    logic [63:0] id;
    logic [63:0] off;
  } result_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic div_start;
    logic apply;
    logic mul_lo;
    logic mul_hi;
    logic finish;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic fin_req;
    logic fin_scale;
    logic div_done;
    logic buf_empty;
  } dp_sts_t;

  // Bytes that follow the type byte for a field code
  function automatic logic [3:0] code_width(input logic [2:0] code);
    logic [3:0] w;
    case (code_t'(code))
      CODE_ABS64:                           w = 4'd8;
      CODE_PLUS1:                           w = 4'd0;
      CODE_ADD_U8, CODE_SUB_U8:             w = 4'd1;
      CODE_ADD_U16, CODE_SUB_U16, CODE_ABS_U16: w = 4'd2;
      default:                              w = 4'd4;
    endcase
    return w;
  endfunction

  // Apply a field code to the previous value, modulo 2^64
  function automatic logic [63:0] apply_code(input logic [2:0] code,
                                             input logic [63:0] base,
                                             input logic [63:0] v);
    logic [63:0] r;
    case (code_t'(code))
      CODE_PLUS1:                 r = base + 64'd1;
      CODE_ADD_U8, CODE_ADD_U16:  r = base + v;
      CODE_SUB_U8, CODE_SUB_U16:  r = base - v;
      default:                    r = v;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

@@ sv/datd_if.sv @@
// Valid/ready channel interfaces for table bytes and decoded results.
`default_nettype none
interface datd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       end_of_file;
  modport source (output valid, data_byte, first_byte, end_of_file, input ready);
  modport sink   (input valid, data_byte, first_byte, end_of_file, output ready);
endinterface

interface datd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [2:0]  error_code;
  logic [63:0] entry_id;
  logic [63:0] entry_offset;
  logic        last;
  modport source (output valid, kind, error_code, entry_id, entry_offset, last,
                  input ready);
  modport sink   (input valid, kind, error_code, entry_id, entry_offset, last,
                  output ready);
endinterface
`default_nettype wire

@@ sv/delta_address_table_decoder.sv @@
// Top level of the delta-coded address table decoder.
// Table bytes arrive one per transfer on in_ch and decoded entries, the
// completion mark and errors leave on out_ch, at most two results per byte
// with last set on the final one. A byte that yields no result does not
// hold up the next byte. A byte that yields results is followed by a pause
// until they are all transferred; a byte that completes an entry takes an
// extra finish step, and an entry with the offset scale bit first goes
// through the 64-step bit-serial divider and then makes two passes through
// the shared 32x32 multiplier.
`default_nettype none
module delta_address_table_decoder
  import datd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  datd_in_if.sink    in_ch,
  datd_out_if.source out_ch
);

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    in_ready;

  assign in_ch.ready = in_ready;

  datd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  datd_datapath u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .sts    (sts),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule
`default_nettype wire

@@ sv/datd_divider.sv @@
// Bit-serial restoring divider, 64-bit dividend by 32-bit divisor.
`default_nettype none
module datd_divider
  import datd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             done,
  output logic [63:0]      quotient
);

  localparam int unsigned CNT_W = $clog2(DIV_STEPS);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [31:0]      rem_r, rem_nxt;
  logic [63:0]      quo_r, quo_nxt;
  logic [32:0]      trial;
  logic [32:0]      diff;

  // One quotient bit per cycle
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    trial    = {rem_r, quo_r[63]};
    diff     = trial - {1'b0, divisor};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      if (!diff[32]) begin
        rem_nxt = diff[31:0];
        quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = trial[31:0];
        quo_nxt = {quo_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

@@ sv/datd_datapath.sv @@
// Parse registers, per-byte field logic, offset scaling and result buffer.
`default_nettype none
module datd_datapath
  import datd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire dp_cmd_t cmd,
  output dp_sts_t      sts,
  datd_in_if.sink      in_ch,
  datd_out_if.source   out_ch
);

  phase_t      phase_r, phase_nxt;
  logic [3:0]  fbl_r, fbl_nxt;
  logic [63:0] asm_r, asm_nxt;
  logic [63:0] pid_r, pid_nxt;
  logic [63:0] poff_r, poff_nxt;
  logic [31:0] ps_r, ps_nxt;
  logic [31:0] el_r, el_nxt;
  logic [31:0] sk_r, sk_nxt;
  logic [7:0]  et_r, et_nxt;
  logic [63:0] pend_r, pend_nxt;
  logic        eof_r;
  logic        push_v;
  result_t     push_res;
  logic        fin_req;
  logic        so_req;
  logic [3:0]  w;
  logic [2:0]  idx;
  logic [31:0] v32;
  logic [3:0]  ow;

  result_t     res0_r, res1_r;
  logic [1:0]  cnt_r;
  logic        pop;

  logic [63:0] quotient;
  logic        div_done;
  logic [63:0] pre_r;
  logic [63:0] plo_r;
  logic [31:0] phi_r;
  logic [31:0] mul_a;
  logic [63:0] prod;
  logic [63:0] fin_off;
  logic [31:0] fin_el;

  // Step of the parse for the byte on the input channel
  always_comb begin
    phase_nxt = phase_r;
    fbl_nxt   = fbl_r;
    asm_nxt   = asm_r;
    pid_nxt   = pid_r;
    poff_nxt  = poff_r;
    ps_nxt    = ps_r;
    el_nxt    = el_r;
    sk_nxt    = sk_r;
    et_nxt    = et_r;
    pend_nxt  = pend_r;
    push_v    = 1'b0;
    push_res  = '{kind: KIND_ERROR, err: ERR_NONE, id: '0, off: '0};
    fin_req   = 1'b0;
    so_req    = 1'b0;
    w         = 4'd4;
    idx       = '0;
    v32       = '0;
    ow        = '0;
    if (in_ch.first_byte || phase_r != PH_IDLE) begin
      if (in_ch.first_byte) begin
        pid_nxt   = '0;
        poff_nxt  = '0;
        phase_nxt = PH_FORMAT;
        fbl_nxt   = 4'd4;
        asm_nxt   = '0;
      end
      if (phase_nxt == PH_VERSION || phase_nxt == PH_NAME) begin
        if (sk_nxt != 32'd0) sk_nxt = sk_nxt - 32'd1;
        if (sk_nxt == 32'd0) begin
          phase_nxt = (phase_nxt == PH_VERSION) ? PH_NAMELEN : PH_PTRSIZE;
          fbl_nxt   = 4'd4;
          asm_nxt   = '0;
        end
      end else if (phase_nxt == PH_TYPE) begin
        et_nxt = in_ch.data_byte;
        if (in_ch.data_byte[3]) begin
          phase_nxt    = PH_IDLE;
          push_v       = 1'b1;
          push_res.err = ERR_BAD_ID;
        end else if (code_t'(in_ch.data_byte[2:0]) == CODE_PLUS1) begin
          pend_nxt = pid_nxt + 64'd1;
          so_req   = 1'b1;
        end else begin
          phase_nxt = PH_IDF;
          fbl_nxt   = code_width(in_ch.data_byte[2:0]);
          asm_nxt   = '0;
        end
      end else begin
        // Little-endian byte assembly
        if (phase_nxt == PH_IDF) w = code_width(et_nxt[2:0]);
        else if (phase_nxt == PH_OFFF) w = code_width(et_nxt[6:4]);
        idx     = 3'(w - fbl_nxt);
        asm_nxt = asm_nxt | ({56'd0, in_ch.data_byte} << {idx, 3'b000});
        if (fbl_nxt != 4'd0) fbl_nxt = fbl_nxt - 4'd1;
        if (fbl_nxt == 4'd0) begin
          v32 = asm_nxt[31:0];
          case (phase_nxt)
            PH_FORMAT: begin
              if (v32 != 32'd1 && v32 != 32'd2) begin
                phase_nxt    = PH_IDLE;
                push_v       = 1'b1;
                push_res.err = ERR_BAD_FORMAT;
              end else begin
                phase_nxt = PH_VERSION;
                sk_nxt    = 32'd16;
              end
            end
            PH_NAMELEN: begin
              sk_nxt = v32;
              if (v32 == 32'd0) begin
                phase_nxt = PH_PTRSIZE;
                fbl_nxt   = 4'd4;
                asm_nxt   = '0;
              end else begin
                phase_nxt = PH_NAME;
              end
            end
            PH_PTRSIZE: begin
              ps_nxt = v32;
              if (v32 == 32'd0) begin
                phase_nxt    = PH_IDLE;
                push_v       = 1'b1;
                push_res.err = ERR_ZERO_PTR;
              end else begin
                phase_nxt = PH_COUNT;
                fbl_nxt   = 4'd4;
                asm_nxt   = '0;
              end
            end
            PH_COUNT: begin
              el_nxt = v32;
              if (v32 == 32'd0) begin
                phase_nxt     = PH_IDLE;
                push_v        = 1'b1;
                push_res.kind = KIND_DONE;
              end else begin
                phase_nxt = PH_TYPE;
              end
            end
            PH_IDF: begin
              pend_nxt = apply_code(et_nxt[2:0], pid_nxt, asm_nxt);
              so_req   = 1'b1;
            end
            default: fin_req = 1'b1;
          endcase
        end
      end
      // Offset field follows the id
      if (so_req) begin
        ow = code_width(et_nxt[6:4]);
        if (ow == 4'd0) begin
          asm_nxt = '0;
          fin_req = 1'b1;
        end else begin
          phase_nxt = PH_OFFF;
          fbl_nxt   = ow;
          asm_nxt   = '0;
        end
      end
      // Truncation; an entry defers this check to the finish step
      if (!fin_req && in_ch.end_of_file && phase_nxt != PH_IDLE) begin
        phase_nxt = PH_IDLE;
        push_v    = 1'b1;
        push_res  = '{kind: KIND_ERROR, err: ERR_TRUNCATED, id: '0, off: '0};
      end
    end
  end

  datd_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (poff_r),
    .divisor  (ps_r),
    .done     (div_done),
    .quotient (quotient)
  );

  // Shared 32x32 multiplier for the two halves of the scaled offset
  assign mul_a = cmd.mul_hi ? pre_r[63:32] : pre_r[31:0];
  assign prod  = 64'(mul_a) * 64'(ps_r);

  // Offset of the finished entry
  assign fin_off = et_r[7] ? (plo_r + {phi_r, 32'd0})
                           : apply_code(et_r[6:4], poff_r, asm_r);
  assign fin_el  = el_r - 32'd1;

  assign pop = out_ch.valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r   <= '0;
    end else begin
      if (cmd.accept) begin
        phase_r <= phase_nxt;
        fbl_r   <= fbl_nxt;
        asm_r   <= asm_nxt;
        pid_r   <= pid_nxt;
        poff_r  <= poff_nxt;
        ps_r    <= ps_nxt;
        el_r    <= el_nxt;
        sk_r    <= sk_nxt;
        et_r    <= et_nxt;
        pend_r  <= pend_nxt;
        eof_r   <= in_ch.end_of_file;
        if (push_v) begin
          res0_r <= push_res;
          cnt_r  <= 2'd1;
        end
      end else if (cmd.finish) begin
        res0_r <= '{kind: KIND_ENTRY, err: ERR_NONE, id: pend_r, off: fin_off};
        pid_r  <= pend_r;
        poff_r <= fin_off;
        el_r   <= fin_el;
        if (fin_el == 32'd0) begin
          res1_r  <= '{kind: KIND_DONE, err: ERR_NONE, id: '0, off: '0};
          cnt_r   <= 2'd2;
          phase_r <= PH_IDLE;
        end else if (eof_r) begin
          res1_r  <= '{kind: KIND_ERROR, err: ERR_TRUNCATED, id: '0, off: '0};
          cnt_r   <= 2'd2;
          phase_r <= PH_IDLE;
        end else begin
          cnt_r   <= 2'd1;
          phase_r <= PH_TYPE;
        end
      end else if (pop) begin
        res0_r <= res1_r;
        cnt_r  <= cnt_r - 2'd1;
      end
    end
    // Scaling pipeline
    if (cmd.apply) begin
      pre_r <= apply_code(et_r[6:4], (ps_r != 32'd0) ? quotient : poff_r, asm_r);
    end
    if (cmd.mul_lo) plo_r <= prod;
    if (cmd.mul_hi) phi_r <= prod[31:0];
  end

  assign sts.fin_req   = fin_req;
  assign sts.fin_scale = et_nxt[7];
  assign sts.div_done  = div_done;
  assign sts.buf_empty = (cnt_r == 2'd0);

  assign out_ch.valid        = (cnt_r != 2'd0);
  assign out_ch.kind         = res0_r.kind;
  assign out_ch.error_code   = res0_r.err;
  assign out_ch.entry_id     = res0_r.id;
  assign out_ch.entry_offset = res0_r.off;
  assign out_ch.last         = (cnt_r == 2'd1);

endmodule
`default_nettype wire

@@ sv/datd_ctrl.sv @@
// Sequencer: byte acceptance, divide, multiply and entry finish steps.
`default_nettype none
`include "assert_macros.svh"
module datd_ctrl
  import datd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire dp_sts_t sts,
  output dp_cmd_t      cmd
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready   = sts.buf_empty;
        cmd.accept = in_valid && sts.buf_empty;
        if (cmd.accept && sts.fin_req) begin
          state_nxt = sts.fin_scale ? ST_DIV_GO : ST_FIN;
        end
      end
      ST_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (sts.div_done) state_nxt = ST_APPLY;
      end
      ST_APPLY: begin
        cmd.apply = 1'b1;
        state_nxt = ST_MUL_LO;
      end
      ST_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = ST_FIN;
      end
      ST_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  `ASSERT_IMP(a_ready_idle, state_r != ST_IDLE, !in_ready, "byte taken while busy")
  `ASSERT_IMP(a_fin_empty, state_r == ST_FIN, sts.buf_empty, "finish over pending results")
  `ASSERT_NXT(a_fin_ret, state_r == ST_FIN, state_r == ST_IDLE, "finish did not return")
  `ASSERT_NXT(a_div_apply, state_r == ST_DIV_WAIT && sts.div_done, state_r == ST_APPLY, "quotient not applied")

endmodule
`default_nettype wire

@@ sim/datd_scoreboard.sv @@
// Checker: watches the byte and result channels, predicts decoded results and compares.
`default_nettype none
module datd_scoreboard
  import datd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  datd_in_if.sink   in_mon,
  datd_out_if.sink  out_mon,
  output int        fail_count,
  output int        pending_count,
  output int        result_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    kind_t       kind;
    err_t        err;
    logic [63:0] id;
    logic [63:0] off;
    logic        last;
  } dec_result_t;

  dec_result_t expected_q[$];
  dec_result_t step_q[$];

  // Decoder state copy
  phase_t      ph;
  logic [3:0]  bytes_left;
  logic [63:0] accum;
  logic [63:0] last_id;
  logic [63:0] last_off;
  logic [31:0] scale_div;
  logic [31:0] remaining;
  logic [31:0] skip_cnt;
  logic [7:0]  type_byte;
  logic [63:0] cur_id;

  function automatic logic [3:0] width_of(input logic [2:0] c);
    case (code_t'(c))
      CODE_ABS64:                               return 4'd8;
      CODE_PLUS1:                               return 4'd0;
      CODE_ADD_U8, CODE_SUB_U8:                 return 4'd1;
      CODE_ADD_U16, CODE_SUB_U16, CODE_ABS_U16: return 4'd2;
      default:                                  return 4'd4;
    endcase
  endfunction

  function automatic logic [63:0] decode_val(input logic [2:0] c, input logic [63:0] b,
                                             input logic [63:0] v);
    case (code_t'(c))
      CODE_PLUS1:                return b + 64'd1;
      CODE_ADD_U8, CODE_ADD_U16: return b + v;
      CODE_SUB_U8, CODE_SUB_U16: return b - v;
      default:                   return v;
    endcase
  endfunction

  task automatic push_result(input kind_t k, input err_t e, input logic [63:0] i,
                             input logic [63:0] o);
    dec_result_t r;
    r.kind = k; r.err = e; r.id = i; r.off = o; r.last = 1'b0;
    step_q.insert(step_q.size(), r);
  endtask

  task automatic begin_field(input phase_t p, input logic [3:0] w);
    ph = p; bytes_left = w; accum = '0;
  endtask

  task automatic close_entry();
    logic [3:0]  hi;
    logic [63:0] base;
    logic [63:0] o;
    hi = type_byte[7:4];
    base = last_off;
    if (hi[3] && scale_div != 32'd0) base = last_off / {32'd0, scale_div};
    o = decode_val(hi[2:0], base, accum);
    if (hi[3]) o = o * {32'd0, scale_div};
    push_result(KIND_ENTRY, ERR_NONE, cur_id, o);
    last_id = cur_id;
    last_off = o;
    remaining = remaining - 32'd1;
    if (remaining == 32'd0) begin
      push_result(KIND_DONE, ERR_NONE, '0, '0);
      ph = PH_IDLE;
    end else begin
      ph = PH_TYPE;
    end
  endtask

  task automatic open_offset();
    logic [3:0] w;
    w = width_of(type_byte[6:4]);
    if (w == 4'd0) begin
      accum = '0;
      close_entry();
    end else begin
      begin_field(PH_OFFF, w);
    end
  endtask

  task automatic field_complete();
    logic [31:0] v;
    v = accum[31:0];
    case (ph)
      PH_FORMAT: begin
        if (v != 32'd1 && v != 32'd2) begin
          ph = PH_IDLE;
          push_result(KIND_ERROR, ERR_BAD_FORMAT, '0, '0);
        end else begin
          ph = PH_VERSION;
          skip_cnt = 32'd16;
        end
      end
      PH_NAMELEN: begin
        skip_cnt = v;
        if (v == 32'd0) begin_field(PH_PTRSIZE, 4'd4);
        else ph = PH_NAME;
      end
      PH_PTRSIZE: begin
        scale_div = v;
        if (v == 32'd0) begin
          ph = PH_IDLE;
          push_result(KIND_ERROR, ERR_ZERO_PTR, '0, '0);
        end else begin
          begin_field(PH_COUNT, 4'd4);
        end
      end
      PH_COUNT: begin
        remaining = v;
        if (v == 32'd0) begin
          ph = PH_IDLE;
          push_result(KIND_DONE, ERR_NONE, '0, '0);
        end else begin
          ph = PH_TYPE;
        end
      end
      PH_IDF: begin
        cur_id = decode_val(type_byte[2:0], last_id, accum);
        open_offset();
      end
      default: close_entry();
    endcase
  endtask

  // Predict the results of one accepted byte
  task automatic predict_byte(input logic [7:0] b, input logic first, input logic eof);
    logic [3:0] w;
    logic [2:0] idx;
    step_q.delete();
    if (first) begin
      last_id = '0;
      last_off = '0;
      begin_field(PH_FORMAT, 4'd4);
    end else if (ph == PH_IDLE) begin
      return;
    end
    if (ph == PH_VERSION || ph == PH_NAME) begin
      if (skip_cnt > 32'd0) skip_cnt = skip_cnt - 32'd1;
      if (skip_cnt == 32'd0) begin
        if (ph == PH_VERSION) begin_field(PH_NAMELEN, 4'd4);
        else begin_field(PH_PTRSIZE, 4'd4);
      end
    end else if (ph == PH_TYPE) begin
      type_byte = b;
      if (b[3]) begin
        ph = PH_IDLE;
        push_result(KIND_ERROR, ERR_BAD_ID, '0, '0);
      end else if (width_of(b[2:0]) == 4'd0) begin
        cur_id = last_id + 64'd1;
        open_offset();
      end else begin
        begin_field(PH_IDF, width_of(b[2:0]));
      end
    end else begin
      if (ph == PH_IDF) w = width_of(type_byte[2:0]);
      else if (ph == PH_OFFF) w = width_of(type_byte[6:4]);
      else w = 4'd4;
      idx = 3'(w - bytes_left);
      accum = accum | ({56'd0, b} << {idx, 3'b000});
      if (bytes_left > 4'd0) bytes_left = bytes_left - 4'd1;
      if (bytes_left == 4'd0) field_complete();
    end
    if (eof && ph != PH_IDLE) begin
      ph = PH_IDLE;
      push_result(KIND_ERROR, ERR_TRUNCATED, '0, '0);
    end
    if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
    foreach (step_q[k]) expected_q.insert(expected_q.size(), step_q[k]);
  endtask

  // Sample transfers on both channels
  always @(posedge clk) begin
    dec_result_t e;
    if (!rst_n) begin
      bytes_left = '0; accum = '0; last_id = '0; last_off = '0;
      scale_div = '0; remaining = '0; skip_cnt = '0; type_byte = '0; cur_id = '0;
      ph = PH_IDLE;
      fail_count <= 0;
      result_count <= 0;
      pending_count <= 0;
      expected_q.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        result_count <= result_count + 1;
        if (expected_q.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: unexpected result kind=%0d err=%0d id=%h off=%h", $realtime,
                     out_mon.kind, out_mon.error_code, out_mon.entry_id,
                     out_mon.entry_offset);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_q.pop_front();
          if (out_mon.kind !== e.kind || out_mon.error_code !== e.err ||
              out_mon.entry_id !== e.id || out_mon.entry_offset !== e.off ||
              out_mon.last !== e.last) begin
            if (fail_count < 10) begin
              $display("%0t: mismatch exp kind=%0d err=%0d id=%h off=%h last=%0b",
                       $realtime, e.kind, e.err, e.id, e.off, e.last);
              $display("%0t:          got kind=%0d err=%0d id=%h off=%h last=%0b",
                       $realtime, out_mon.kind, out_mon.error_code, out_mon.entry_id,
                       out_mon.entry_offset, out_mon.last);
            end
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        predict_byte(in_mon.data_byte, in_mon.first_byte, in_mon.end_of_file);
      pending_count <= expected_q.size();
    end
  end
endmodule
`default_nettype wire

@@ sim/delta_address_table_decoder_test.sv @@
// Testbench top: drives table files into the decoder and reports the verdict.
`default_nettype none
module delta_address_table_decoder_test
  import datd_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk;
  logic rst_n;
  int   fail_count, pending_count, result_count;
  int   src_idle_pct, snk_idle_pct;
  int   byte_count, file_count;
  int   base_bytes;
  logic [7:0] file_q[$];
  logic       eof_at_end;

  datd_in_if  in_ch();
  datd_out_if out_ch();

  delta_address_table_decoder u_top (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  datd_scoreboard u_check (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch),
    .fail_count(fail_count), .pending_count(pending_count), .result_count(result_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("TEST FAILED");
    $finish;
  end

  // Receiver stalls
  initial out_ch.ready = 1'b0;
  always @(posedge clk)
    out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);

  task automatic put8(input logic [7:0] v);
    file_q.insert(file_q.size(), v);
  endtask

  task automatic put32(input logic [31:0] v);
    for (int k = 0; k < 4; k++) put8(v[8*k +: 8]);
  endtask

  task automatic put_field(input logic [2:0] c, input logic [63:0] v);
    logic [3:0] w;
    case (code_t'(c))
      CODE_ABS64:                               w = 4'd8;
      CODE_PLUS1:                               w = 4'd0;
      CODE_ADD_U8, CODE_SUB_U8:                 w = 4'd1;
      CODE_ADD_U16, CODE_SUB_U16, CODE_ABS_U16: w = 4'd2;
      default:                                  w = 4'd4;
    endcase
    for (int k = 0; k < w; k++) put8(v[8*k +: 8]);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Header: format, versions, name, pointer size, count
  task automatic put_header(input logic [31:0] fmt, input logic [31:0] name_len,
                            input logic [31:0] psize, input logic [31:0] cnt);
    put32(fmt);
    for (int k = 0; k < 4; k++) put32($urandom());
    put32(name_len);
    for (int k = 0; k < name_len; k++) put8(8'($urandom()));
    put32(psize);
    put32(cnt);
  endtask

  // One entry of type t with random field values
  task automatic put_entry(input logic [7:0] t);
    put8(t);
    put_field(t[2:0], rand64());
    put_field(t[6:4], rand64());
  endtask

  // Send the queued file; first byte marked, eof optional on the final byte
  task automatic send_file();
    for (int k = 0; k < file_q.size(); k++) begin
      while ($urandom_range(99) < src_idle_pct) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
      in_ch.valid       <= 1'b1;
      in_ch.data_byte   <= file_q[k];
      in_ch.first_byte  <= (k == 0);
      in_ch.end_of_file <= eof_at_end && (k == file_q.size() - 1);
      @(posedge clk);
      while (!in_ch.ready) @(posedge clk);
      byte_count++;
    end
    in_ch.valid <= 1'b0;
    file_q.delete();
    file_count++;
  endtask

  task automatic random_file();
    int n, pick;
    logic [7:0] t;
    pick = $urandom_range(99);
    eof_at_end = ($urandom_range(3) == 0);
    if (pick < 6) put32($urandom_range(3) == 0 ? 32'hFFFF_FFFF : 32'($urandom_range(6)));
    else if (pick < 10) put_header(2, 0, 0, 5);
    else begin
      n = $urandom_range(6);
      put_header($urandom_range(1, 2), $urandom_range(0, 3),
                 $urandom_range(3) == 0 ? $urandom() : $urandom_range(1, 16), n);
      for (int e = 0; e < n; e++) begin
        t = 8'($urandom());
        t[3] = ($urandom_range(30) == 0);
        if ($urandom_range(2) != 0) t[7] = 1'b0;
        put_entry(t);
      end
      if (file_q.size() > 2 && $urandom_range(9) == 0)
        for (int k = $urandom_range(1, 6); k > 0 && file_q.size() > 1; k--)
          void'(file_q.pop_back());
      if ($urandom_range(7) == 0)
        for (int k = 0; k < 3; k++) put8(8'($urandom()));
    end
    send_file();
  endtask

  task automatic directed_files();
    eof_at_end = 1'b0;
    put32(32'd3); send_file();                             // bad format
    put_header(1, 2, 0, 1); send_file();                   // zero pointer size
    put_header(2, 0, 8, 0); send_file();                   // zero entry count
    put_header(1, 1, 8, 9);
    put_entry(8'h00); put_entry(8'h11); put_entry(8'h32); put_entry(8'h23);
    put_entry(8'h54); put_entry(8'h45); put_entry(8'h76); put_entry(8'h67);
    put_entry(8'hF0);
    send_file();                                           // every code, random values
    put_header(1, 0, 32'hFFFF_FFFF, 3);
    put_entry(8'h80); put_entry(8'hB1); put_entry(8'hD7); send_file();
    put_header(2, 0, 4, 2); put_entry(8'h0F); send_file(); // bad id code
    put_header(2, 0, 4, 1); eof_at_end = 1'b1;
    put_entry(8'h11); send_file();                         // entry on the eof byte
    put_header(2, 0, 4, 2); put_entry(8'h11); send_file(); // entry then truncation
    put_header(2, 0, 4, 2); void'(file_q.pop_back()); send_file(); // truncated header
    put32(32'd7); send_file();                             // format error on eof byte
    eof_at_end = 1'b0;
    put_header(1, 0, 4, 3); put_entry(8'h00); send_file(); // left mid-parse, restart
  endtask

  task automatic wait_drain();
    while (pending_count != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // Stimulus
  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0; in_ch.data_byte = '0; in_ch.first_byte = 1'b0;
    in_ch.end_of_file = 1'b0;
    src_idle_pct = 25; snk_idle_pct = 54;
    byte_count = 0; file_count = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // stray bytes with no first flag while idle, with eof too
    for (int k = 0; k < 3; k++) begin
      in_ch.valid <= 1'b1; in_ch.data_byte <= 8'($urandom());
      in_ch.first_byte <= 1'b0; in_ch.end_of_file <= (k == 2);
      @(posedge clk);
      while (!in_ch.ready) @(posedge clk);
    end
    in_ch.valid <= 1'b0;
    directed_files();
    base_bytes = byte_count;
    for (int p = 0; p < 3; p++) begin
      if (p == 1) begin src_idle_pct = 54; snk_idle_pct = 25; end
      if (p == 2) begin src_idle_pct = 0; snk_idle_pct = 0; end
      while (byte_count < base_bytes + 45 * (p + 1)) random_file();
    end
    wait_drain();
    $display("Sent %0d files (%0d bytes); %0d results checked.", file_count, byte_count,
             result_count);
    $display("Covered all field codes, scaling, header errors, truncation and restarts.");
    if (fail_count == 0 && pending_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
